// ===== hw/rtl/hrfp_pkg.sv =====
// Shared types and codes for the HTTP request / form parser.
// No dependencies; used by the front end, back end and top level.
`default_nettype none

package hrfp_pkg;

  // byte classes found by the front end
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_OTHER = 3'd0;
  localparam cls_t CLS_SPACE = 3'd1;
  localparam cls_t CLS_CR    = 3'd2;
  localparam cls_t CLS_LF    = 3'd3;
  localparam cls_t CLS_AMP   = 3'd4;
  localparam cls_t CLS_EQ    = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // field kinds
  localparam logic [1:0] KIND_METHOD = 2'd0;
  localparam logic [1:0] KIND_URI    = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;
  localparam logic [1:0] KIND_VALUE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_NO_BODY = 2'd2;

  // pair index saturates at this count
  localparam int unsigned PAIR_CAP = 255;

  // classified input byte, front to back
  typedef struct packed {
    logic [7:0] data;
    logic       eor;
    cls_t       cls;
  } cls_item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0] field_kind;
    logic       char_valid;
    logic [7:0] char_out;
    logic       field_end;
    logic [7:0] pair_number;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hrfp_fifo.sv =====
// Small register FIFO used between the parser stages and at the output.
// No package dependency; depth is a power of two set by AW.
`default_nettype none

module hrfp_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(do_wr);
    rd_ptr_nxt = rd_ptr_r + AW'(do_rd);
    count_nxt  = count_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hrfp_front.sv =====
// Front end: takes request bytes and tags each with its delimiter class.
// Depends on hrfp_pkg; feeds the middle queue.
`default_nettype none

module hrfp_front (
  input  wire logic               push,
  input  wire logic [7:0]         byte_in,
  input  wire logic               end_of_request,
  input  wire logic               q_full,
  output logic                    q_wr,
  output hrfp_pkg::cls_item_t     q_item
);

  import hrfp_pkg::*;

  cls_t cls;

  // delimiter decode
  always_comb begin
    case (byte_in)
      CH_SPACE: cls = CLS_SPACE;
      CH_CR:    cls = CLS_CR;
      CH_LF:    cls = CLS_LF;
      CH_AMP:   cls = CLS_AMP;
      CH_EQ:    cls = CLS_EQ;
      default:  cls = CLS_OTHER;
    endcase
  end

  assign q_wr        = push && !q_full;
  assign q_item.data = byte_in;
  assign q_item.eor  = end_of_request;
  assign q_item.cls  = cls;

endmodule

`default_nettype wire

// ===== hw/rtl/hrfp_back.sv =====
// Back end: request line/header/form FSM, one byte per cycle if unstalled.
// Depends on hrfp_pkg; reads the middle queue and writes the result queue.
`default_nettype none

module hrfp_back #(
  parameter int MAX_METHOD_LEN = 7,
  parameter int MAX_FIELD_LEN  = 255,
  parameter int MAX_PAIRS      = 255
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  hrfp_pkg::cls_item_t     q_item,
  output logic                    q_rd,
  input  wire logic               res_full,
  output logic                    res_wr,
  output hrfp_pkg::result_t       res
);

  import hrfp_pkg::*;

  localparam int LEN_W      = $clog2(MAX_FIELD_LEN + 1);
  localparam int PAIR_LIMIT = (MAX_PAIRS > PAIR_CAP) ? PAIR_CAP : MAX_PAIRS;

  localparam logic [2:0] PH_METHOD = 3'd0;
  localparam logic [2:0] PH_URI    = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_VALUE  = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic [1:0]       match_r, match_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       pairs_r, pairs_nxt;
  logic             trunc_r, trunc_nxt;
  logic             open_r, open_nxt;

  logic             step;
  logic             have;
  logic [LEN_W-1:0] lim;
  logic             keep;
  logic [2:0]       m;
  logic             fld_open;
  logic [1:0]       open_kind;
  result_t          r;

  assign step   = !q_empty && !res_full;
  assign q_rd   = step;
  assign lim    = (phase_r == PH_METHOD) ? LEN_W'(MAX_METHOD_LEN) : LEN_W'(MAX_FIELD_LEN);
  assign keep   = (len_r < lim);

  // per-byte parse step
  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    len_nxt   = len_r;
    pairs_nxt = pairs_r;
    trunc_nxt = trunc_r;
    open_nxt  = open_r;
    have      = 1'b0;
    r         = '0;
    m         = 3'd0;
    fld_open  = 1'b0;
    open_kind = KIND_METHOD;

    case (phase_r)
      PH_METHOD, PH_URI: begin
        if (q_item.cls == CLS_SPACE) begin
          have        = 1'b1;
          r.field_kind = (phase_r == PH_METHOD) ? KIND_METHOD : KIND_URI;
          r.field_end = 1'b1;
          phase_nxt   = (phase_r == PH_METHOD) ? PH_URI : PH_HEADER;
          match_nxt   = 2'd0;
          len_nxt     = '0;
        end else if (keep) begin
          have         = 1'b1;
          r.field_kind = (phase_r == PH_METHOD) ? KIND_METHOD : KIND_URI;
          r.char_valid = 1'b1;
          r.char_out   = q_item.data;
          len_nxt      = len_r + LEN_W'(1);
        end else begin
          trunc_nxt = 1'b1;
        end
      end
      PH_HEADER: begin
        // CR LF CR LF: even positions want CR, odd ones LF
        if (match_r[0] ? (q_item.cls == CLS_LF) : (q_item.cls == CLS_CR)) begin
          m = {1'b0, match_r} + 3'd1;
        end else if (q_item.cls == CLS_CR) begin
          m = 3'd1;
        end else begin
          m = 3'd0;
        end
        if (m[2]) begin
          phase_nxt = PH_KEY;
          match_nxt = 2'd0;
          open_nxt  = 1'b0;
          len_nxt   = '0;
        end else begin
          match_nxt = m[1:0];
        end
      end
      PH_KEY: begin
        if (q_item.cls == CLS_AMP) begin
          // empty pair is skipped
          if (open_r) begin
            have          = 1'b1;
            r.field_kind  = KIND_KEY;
            r.field_end   = 1'b1;
            r.pair_number = pairs_r;
            pairs_nxt     = (pairs_r < 8'(PAIR_CAP)) ? pairs_r + 8'd1 : pairs_r;
            open_nxt      = 1'b0;
            len_nxt       = '0;
          end
        end else if (!open_r && (pairs_r >= 8'(PAIR_LIMIT))) begin
          trunc_nxt = 1'b1;
          phase_nxt = PH_SKIP;
        end else begin
          // length is already zero whenever no pair is open
          open_nxt = 1'b1;
          if (q_item.cls == CLS_EQ) begin
            have          = 1'b1;
            r.field_kind  = KIND_KEY;
            r.field_end   = 1'b1;
            r.pair_number = pairs_r;
            phase_nxt     = PH_VALUE;
            len_nxt       = '0;
          end else if (keep) begin
            have          = 1'b1;
            r.field_kind  = KIND_KEY;
            r.char_valid  = 1'b1;
            r.char_out    = q_item.data;
            r.pair_number = pairs_r;
            len_nxt       = len_r + LEN_W'(1);
          end else begin
            trunc_nxt = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        if (q_item.cls == CLS_AMP) begin
          have          = 1'b1;
          r.field_kind  = KIND_VALUE;
          r.field_end   = 1'b1;
          r.pair_number = pairs_r;
          pairs_nxt     = (pairs_r < 8'(PAIR_CAP)) ? pairs_r + 8'd1 : pairs_r;
          open_nxt      = 1'b0;
          len_nxt       = '0;
          phase_nxt     = PH_KEY;
        end else if (keep) begin
          have          = 1'b1;
          r.field_kind  = KIND_VALUE;
          r.char_valid  = 1'b1;
          r.char_out    = q_item.data;
          r.pair_number = pairs_r;
          len_nxt       = len_r + LEN_W'(1);
        end else begin
          trunc_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // request end: close any open field, report status, restart
    if (q_item.eor) begin
      case (phase_nxt)
        PH_METHOD: begin fld_open = 1'b1; open_kind = KIND_METHOD; end
        PH_URI:    begin fld_open = 1'b1; open_kind = KIND_URI;    end
        PH_KEY:    begin fld_open = open_nxt; open_kind = open_nxt ? KIND_KEY : KIND_METHOD; end
        PH_VALUE:  begin fld_open = 1'b1; open_kind = KIND_VALUE;  end
        default:   begin fld_open = 1'b0; open_kind = KIND_METHOD; end
      endcase
      if (have) begin
        r.field_end = r.field_end || fld_open;
      end else begin
        r.field_kind  = open_kind;
        r.field_end   = fld_open;
        r.pair_number = open_kind[1] ? pairs_nxt : 8'd0;
      end
      have   = 1'b1;
      r.last = 1'b1;
      if (phase_nxt == PH_METHOD || phase_nxt == PH_URI || phase_nxt == PH_HEADER) begin
        r.status = ST_NO_BODY;
      end else begin
        r.status = trunc_nxt ? ST_TRUNC : ST_OK;
      end
      phase_nxt = PH_METHOD;
      match_nxt = 2'd0;
      len_nxt   = '0;
      pairs_nxt = 8'd0;
      trunc_nxt = 1'b0;
      open_nxt  = 1'b0;
    end else if (have) begin
      r.status = trunc_nxt ? ST_TRUNC : ST_OK;
    end
  end

  assign res_wr = step && have;
  assign res    = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      match_r <= 2'd0;
      len_r   <= '0;
      pairs_r <= 8'd0;
      trunc_r <= 1'b0;
      open_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      len_r   <= len_nxt;
      pairs_r <= pairs_nxt;
      trunc_r <= trunc_nxt;
      open_r  <= open_nxt;
    end
  end

  // end of request always leaves the parser back at the method phase
  a_eor_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && q_item.eor) |=> (phase_r == PH_METHOD && pairs_r == 8'd0 && !trunc_r))
    else $error("parser state not cleared after end of request");

  // the last byte of a request always produces a result
  a_eor_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && q_item.eor) |-> (res_wr && res.last))
    else $error("end of request without a final result");

  // skipping the body only happens after a pair overflow
  a_skip_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> trunc_r)
    else $error("skip phase without truncation flag");

  // pair index never runs past the pair limit
  a_pair_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pairs_r <= 8'(PAIR_LIMIT))
    else $error("pair index beyond limit");

  // field length stays within the field limit
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_FIELD_LEN))
    else $error("field length beyond limit");

endmodule

`default_nettype wire

// ===== hw/rtl/http_request_form_parser.sv =====
// Top level of the HTTP request line and urlencoded form parser.
// Depends on hrfp_pkg, hrfp_front, hrfp_fifo and hrfp_back.
`default_nettype none

// Accepts one request byte per clock while full is low and produces at most
// one result per byte, so the sustained rate is one byte per cycle while
// results are popped; that figure is set by the back end's single parse-state
// update per byte. An accepted byte is classified into a four-entry queue,
// parsed by the back end from there and written into the result queue, from
// which the result shows on the result ports. Bytes that give no result still
// take a parse step in the back end. A two-entry result queue lets input keep
// flowing while a result waits to be popped; full rises once the middle queue fills.
module http_request_form_parser #(
  parameter int MAX_METHOD_LEN = 7,
  parameter int MAX_FIELD_LEN  = 255,
  parameter int MAX_PAIRS      = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input transactions
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_end_of_request,
  // result transactions
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      out_field_kind,
  output logic            out_char_valid,
  output logic [7:0]      out_char_out,
  output logic            out_field_end,
  output logic [7:0]      out_pair_number,
  output logic [1:0]      out_status,
  output logic            out_last
);

  import hrfp_pkg::*;

  localparam int MID_AW = 2;
  localparam int RES_AW = 1;

  logic      mid_wr, mid_rd, mid_full, mid_empty;
  cls_item_t mid_in, mid_out;
  logic      res_wr, res_full;
  result_t   res_in, res_out;

  // front end: classify and queue
  hrfp_front u_front (
    .push           (push),
    .byte_in        (in_byte_in),
    .end_of_request (in_end_of_request),
    .q_full         (mid_full),
    .q_wr           (mid_wr),
    .q_item         (mid_in)
  );

  assign full = mid_full;

  hrfp_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .AW    (MID_AW)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_in),
    .rd_en   (mid_rd),
    .rd_data (mid_out),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  // back end: parse state machine
  hrfp_back #(
    .MAX_METHOD_LEN (MAX_METHOD_LEN),
    .MAX_FIELD_LEN  (MAX_FIELD_LEN),
    .MAX_PAIRS      (MAX_PAIRS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (mid_empty),
    .q_item   (mid_out),
    .q_rd     (mid_rd),
    .res_full (res_full),
    .res_wr   (res_wr),
    .res      (res_in)
  );

  // result queue
  hrfp_fifo #(
    .WIDTH ($bits(result_t)),
    .AW    (RES_AW)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_field_kind  = res_out.field_kind;
  assign out_char_valid  = res_out.char_valid;
  assign out_char_out    = res_out.char_out;
  assign out_field_end   = res_out.field_end;
  assign out_pair_number = res_out.pair_number;
  assign out_status      = res_out.status;
  assign out_last        = res_out.last;

endmodule

`default_nettype wire
